### design/i2crt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crt_pkg
// Types, codes and helpers shared by the register transfer sequencer.
// ----------------------------------------------------------------------------
package i2crt_pkg;

  // command codes of an input item
  typedef enum logic [2:0] {
    FUNC_READ  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_EVENT = 3'd2,
    FUNC_TICK  = 3'd3,
    FUNC_BYTE  = 3'd4
  } func_e;

  // actions handed to the bus engine or host
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_RACK  = 3'd3,
    ACT_RNACK = 3'd4,
    ACT_STOP  = 3'd5,
    ACT_DIS   = 3'd6,
    ACT_REQ   = 3'd7
  } action_e;

  // sequencer phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_START  = 9'b000000010,
    PH_SLAW   = 9'b000000100,
    PH_SUB    = 9'b000001000,
    PH_RSTART = 9'b000010000,
    PH_SLAR   = 9'b000100000,
    PH_RX     = 9'b001000000,
    PH_TXNEED = 9'b010000000,
    PH_TXWAIT = 9'b100000000
  } phase_e;

  // bus engine status codes
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  // configuration register indexes and reset values
  localparam logic CFG_MAX_RETRIES = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;
  localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
  localparam int unsigned CFG_DATA_W      = 16;

  // one result item
  typedef struct packed {
    action_e    action;
    logic [7:0] out_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic       failed;
    logic [7:0] byte_count;
    logic       last;
  } result_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t mk_res(
    input action_e    act,
    input logic [7:0] ob,
    input logic       rxv,
    input logic [7:0] rxd,
    input logic       done,
    input logic       fail,
    input logic [7:0] cnt,
    input logic       lst
  );
    result_t r;
    r.action     = act;
    r.out_byte   = ob;
    r.rx_valid   = rxv;
    r.rx_data    = rxd;
    r.done_res   = done;
    r.failed     = fail;
    r.byte_count = cnt;
    r.last       = lst;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/i2crt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crt channel interfaces
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface i2crt_in_if import i2crt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] dev_addr;
  logic [7:0] sub_addr;
  logic [7:0] length;
  logic [7:0] bus_status;
  logic [7:0] rx_byte;
  logic [7:0] tx_byte;

  modport source (
    output valid, func, dev_addr, sub_addr, length, bus_status, rx_byte, tx_byte,
    input  ready
  );
  modport sink (
    input  valid, func, dev_addr, sub_addr, length, bus_status, rx_byte, tx_byte,
    output ready
  );
endinterface

interface i2crt_out_if import i2crt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] out_byte;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic       done_res;
  logic       failed;
  logic [7:0] byte_count;
  logic       last;

  modport source (
    output valid, action, out_byte, rx_valid, rx_data, done_res, failed,
           byte_count, last,
    input  ready
  );
  modport sink (
    input  valid, action, out_byte, rx_valid, rx_data, done_res, failed,
           byte_count, last,
    output ready
  );
endinterface
`default_nettype wire

### design/i2crt_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crt_seq
// Transfer state, configuration registers and the per-item decision logic.
// Each accepted item makes one state step and yields up to two results.
// ----------------------------------------------------------------------------
module i2crt_seq import i2crt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  room,
  i2crt_in_if.sink                   in_ch,
  output push_t                      push
);

  phase_e      phase, phase_next;
  logic        is_read, is_read_next;
  logic [7:0]  saved_dev_addr, saved_dev_addr_next;
  logic [7:0]  saved_sub_addr, saved_sub_addr_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  bytes_done, bytes_done_next;
  logic [7:0]  restart_count, restart_count_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0]  max_retries;
  logic [15:0] timeout_ticks;

  logic        in_fire;
  logic [7:0]  st;
  logic [15:0] wait_inc;
  logic [7:0]  left_dec;
  logic [7:0]  done_inc;
  result_t     fail_res;
  result_t     last_res;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;
  assign st          = in_ch.bus_status;
  assign wait_inc    = (wait_count == 16'hFFFF) ? wait_count : wait_count + 16'd1;
  assign left_dec    = bytes_left - 8'd1;
  assign done_inc    = bytes_done + 8'd1;
  assign last_res    = (push.count == 2'd2) ? push.second : push.first;

  // failure: no stop while a start is still pending
  assign fail_res = mk_res((phase == PH_START) ? ACT_NONE : ACT_STOP,
                           8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1);

  // next state and results
  always_comb begin
    phase_next          = phase;
    is_read_next        = is_read;
    saved_dev_addr_next = saved_dev_addr;
    saved_sub_addr_next = saved_sub_addr;
    bytes_left_next     = bytes_left;
    bytes_done_next     = bytes_done;
    restart_count_next  = restart_count;
    wait_count_next     = wait_count;
    push.count          = 2'd0;
    push.first          = '0;
    push.second         = '0;

    if (in_fire) begin
      unique case (in_ch.func)
        FUNC_READ, FUNC_WRITE: begin
          if (phase == PH_IDLE) begin
            is_read_next        = (in_ch.func == FUNC_READ);
            saved_dev_addr_next = in_ch.dev_addr;
            saved_sub_addr_next = in_ch.sub_addr;
            bytes_left_next     = in_ch.length;
            bytes_done_next     = 8'd0;
            wait_count_next     = 16'd0;
            push.count          = 2'd2;
            push.first = mk_res(ACT_DIS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
            if (max_retries == 8'd0) begin
              restart_count_next = 8'd0;
              push.second = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1);
              phase_next  = PH_IDLE;
            end else begin
              restart_count_next = 8'd1;
              push.second = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
              phase_next  = PH_START;
            end
          end
        end

        FUNC_EVENT: begin
          if (phase != PH_IDLE) begin
            push.count = 2'd1;
            push.first = fail_res;
            phase_next = PH_IDLE;
            unique case (phase)
              PH_START, PH_RSTART: begin
                priority if (st == ST_START || st == ST_RSTART) begin
                  push.first = mk_res(ACT_SEND,
                                      (phase == PH_START) ? saved_dev_addr
                                                          : (saved_dev_addr | 8'h01),
                                      1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = (phase == PH_START) ? PH_SLAW : PH_SLAR;
                  wait_count_next = 16'd0;
                end else if (st == ST_ARB_LOST) begin
                  push.first = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = PH_START;
                  wait_count_next = 16'd0;
                end else begin
                end
              end
              PH_SLAW: begin
                priority if (st == ST_SLAW_ACK) begin
                  push.first = mk_res(ACT_SEND, saved_sub_addr, 1'b0, 8'h00,
                                      1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = PH_SUB;
                  wait_count_next = 16'd0;
                end else if (st == ST_SLAW_NACK) begin
                  // address nack: disable, then retry or give up
                  push.count = 2'd2;
                  push.first = mk_res(ACT_DIS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
                  if (restart_count >= max_retries) begin
                    push.second = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00,
                                         1'b1, 1'b1, 8'h00, 1'b1);
                    phase_next  = PH_IDLE;
                  end else begin
                    restart_count_next = restart_count + 8'd1;
                    push.second = mk_res(ACT_START, 8'h00, 1'b0, 8'h00,
                                         1'b0, 1'b0, 8'h00, 1'b1);
                    phase_next      = PH_START;
                    wait_count_next = 16'd0;
                  end
                end else if (st == ST_ARB_LOST) begin
                  push.first = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = PH_START;
                  wait_count_next = 16'd0;
                end else begin
                end
              end
              PH_SUB: begin
                priority if (st == ST_DATA_ACK) begin
                  priority if (is_read) begin
                    push.first = mk_res(ACT_START, 8'h00, 1'b0, 8'h00,
                                        1'b0, 1'b0, 8'h00, 1'b1);
                    phase_next      = PH_RSTART;
                    wait_count_next = 16'd0;
                  end else if (bytes_left == 8'd0) begin
                    push.first = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00,
                                        1'b1, 1'b0, bytes_done, 1'b1);
                  end else begin
                    push.first = mk_res(ACT_REQ, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                    phase_next = PH_TXNEED;
                  end
                end else if (st == ST_DATA_NACK) begin
                  push.first = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00,
                                      1'b1, 1'b0, bytes_done, 1'b1);
                end else if (st == ST_ARB_LOST) begin
                  push.first = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = PH_START;
                  wait_count_next = 16'd0;
                end else begin
                end
              end
              PH_SLAR: begin
                priority if (st == ST_SLAR_ACK && bytes_left != 8'd0) begin
                  bytes_left_next = left_dec;
                  push.first = mk_res((left_dec != 8'd0) ? ACT_RACK : ACT_RNACK, 8'h00,
                                      1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = PH_RX;
                  wait_count_next = 16'd0;
                end else if (st == ST_SLAR_ACK || st == ST_SLAR_NACK) begin
                  push.first = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00,
                                      1'b1, 1'b0, bytes_done, 1'b1);
                end else if (st == ST_ARB_LOST) begin
                  push.first = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                  phase_next      = PH_START;
                  wait_count_next = 16'd0;
                end else begin
                end
              end
              PH_RX: begin
                if (st == ST_RX_ACK || st == ST_RX_NACK) begin
                  bytes_done_next = done_inc;
                  if (st == ST_RX_NACK || bytes_left == 8'd0) begin
                    push.first = mk_res(ACT_STOP, 8'h00, 1'b1, in_ch.rx_byte,
                                        1'b1, 1'b0, done_inc, 1'b1);
                  end else begin
                    bytes_left_next = left_dec;
                    push.first = mk_res((left_dec != 8'd0) ? ACT_RACK : ACT_RNACK, 8'h00,
                                        1'b1, in_ch.rx_byte, 1'b0, 1'b0, 8'h00, 1'b1);
                    phase_next      = PH_RX;
                    wait_count_next = 16'd0;
                  end
                end
              end
              PH_TXWAIT: begin
                if (st == ST_DATA_ACK) begin
                  bytes_done_next = done_inc;
                  if (bytes_left == 8'd0) begin
                    push.first = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00,
                                        1'b1, 1'b0, done_inc, 1'b1);
                  end else begin
                    push.first = mk_res(ACT_REQ, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
                    phase_next = PH_TXNEED;
                  end
                end
              end
              default: begin
                // waiting for a host byte: any event is unexpected
              end
            endcase
          end
        end

        FUNC_TICK: begin
          if (phase != PH_IDLE && phase != PH_TXNEED) begin
            wait_count_next = wait_inc;
            if (wait_inc >= timeout_ticks) begin
              push.count = 2'd1;
              push.first = fail_res;
              phase_next = PH_IDLE;
            end
          end
        end

        FUNC_BYTE: begin
          if (phase == PH_TXNEED) begin
            bytes_left_next = left_dec;
            push.count      = 2'd1;
            push.first = mk_res(ACT_SEND, in_ch.tx_byte, 1'b0, 8'h00,
                                1'b0, 1'b0, 8'h00, 1'b1);
            phase_next      = PH_TXWAIT;
            wait_count_next = 16'd0;
          end
        end

        default: begin
          // unused command codes are ignored
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_read        <= 1'b0;
      saved_dev_addr <= 8'd0;
      saved_sub_addr <= 8'd0;
      bytes_left     <= 8'd0;
      bytes_done     <= 8'd0;
      restart_count  <= 8'd0;
      wait_count     <= 16'd0;
    end else begin
      phase          <= phase_next;
      is_read        <= is_read_next;
      saved_dev_addr <= saved_dev_addr_next;
      saved_sub_addr <= saved_sub_addr_next;
      bytes_left     <= bytes_left_next;
      bytes_done     <= bytes_done_next;
      restart_count  <= restart_count_next;
      wait_count     <= wait_count_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries   <= MAX_RETRIES_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_RETRIES: max_retries   <= cfg_data[7:0];
        CFG_TIMEOUT:     timeout_ticks <= cfg_data;
      endcase
    end
  end

  // a begin from idle with attempts left leaves one attempt charged
  a_begin_charges: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_ch.func == FUNC_READ || in_ch.func == FUNC_WRITE) &&
     phase == PH_IDLE && max_retries != 8'd0)
    |=> (phase == PH_START && restart_count == 8'd1))
    else $error("begin did not charge one attempt");

  // a finishing result always returns the sequencer to idle
  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (in_fire && push.count != 2'd0 && last_res.done_res) |=> phase == PH_IDLE)
    else $error("transfer finished but phase not idle");

  // a result is only produced for an accepted item
  a_push_on_fire: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> in_fire)
    else $error("results without accepted item");

endmodule
`default_nettype wire

### design/i2crt_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crt_res_fifo
// Result queue: takes up to two results per cycle, hands out one per
// transfer, and reports room for two more.
// ----------------------------------------------------------------------------
module i2crt_res_fifo import i2crt_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  push_t      push,
  output logic       room,
  i2crt_out_if.source out_ch
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr_inc;
  logic [CNT_W-1:0]   count;
  logic               pop;
  result_t            head;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign room       = (count <= CNT_W'(DEPTH - 2));
  assign pop        = out_ch.valid && out_ch.ready;
  assign wr_ptr_inc = ptr_inc(wr_ptr);
  assign wr_ptr_next = (push.count == 2'd2) ? ptr_inc(wr_ptr_inc) :
                       (push.count == 2'd1) ? wr_ptr_inc : wr_ptr;

  // head of queue drives the output channel
  assign head              = entries[rd_ptr];
  assign out_ch.valid      = (count != '0);
  assign out_ch.action     = head.action;
  assign out_ch.out_byte   = head.out_byte;
  assign out_ch.rx_valid   = head.rx_valid;
  assign out_ch.rx_data    = head.rx_data;
  assign out_ch.done_res   = head.done_res;
  assign out_ch.failed     = head.failed;
  assign out_ch.byte_count = head.byte_count;
  assign out_ch.last       = head.last;

  // result storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_inc] <= push.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  // never more results queued than entries
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // writes only arrive when two entries are free
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push without room");

  // a lone pop drains exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == $past(count) - CNT_W'(1))
    else $error("fill count wrong after pop");

endmodule
`default_nettype wire

### design/i2c_register_transfer_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_transfer_master
// Sequences sub-addressed register reads and writes over a byte-level bus
// engine, turning commands, status events, ticks and write bytes into bus
// actions, received bytes and completion reports.
// ----------------------------------------------------------------------------
//  port       dir   kind         contents
//  in_ch      in    valid/ready  func, dev_addr, sub_addr, length,
//                                bus_status, rx_byte, tx_byte
//  out_ch     out   valid/ready  action, out_byte, rx_valid, rx_data,
//                                done_res, failed, byte_count, last
//  cfg_*      in    write only   index 0 max_retries, index 1 timeout_ticks
//
//  one command item is accepted per cycle while in_ch.ready is high; its state
//  step completes at that edge; its results, at most two, go to the queue
//  results leave at one per cycle while out_ch.ready is high, the two of an
//  item in turn, so the queue depth sets how far input runs ahead
//  in_ch.ready drops only when fewer than two queue entries are free
//  synchronous reset returns to idle with max_retries 3, timeout_ticks 1000
// ----------------------------------------------------------------------------
module i2c_register_transfer_master import i2crt_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  i2crt_in_if.sink                   in_ch,
  i2crt_out_if.source                out_ch
);

  push_t push;
  logic  room;

  // transfer sequencer
  i2crt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room      (room),
    .in_ch     (in_ch),
    .push      (push)
  );

  // result queue
  i2crt_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### sim/i2crt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crt_checker
// Watches the command and result channels of the register transfer
// sequencer. It keeps its own copy of the sequencer state and register
// settings, predicts the results of every accepted command transfer, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2crt_checker import i2crt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  i2crt_in_if                   in_ch,
  i2crt_out_if                  out_ch,
  output int                    errors,
  output int                    outstanding
);

  // register copies
  logic [7:0]  retry_limit;
  logic [15:0] tick_limit;

  // sequencer copy
  phase_e      seq_phase;
  logic        rd_xfer;
  logic [7:0]  dev_q;
  logic [7:0]  sub_q;
  logic [7:0]  remaining;
  logic [7:0]  moved;
  logic [7:0]  attempts;
  logic [15:0] ticks_waited;

  // results still owed by the block, oldest first
  result_t     pending_results[$];

  function automatic void emit(action_e act, logic [7:0] ob, logic rxv, logic [7:0] rxd,
                               logic dn, logic fl, logic [7:0] cnt, logic lst);
    result_t r;
    r.action     = act;
    r.out_byte   = ob;
    r.rx_valid   = rxv;
    r.rx_data    = rxd;
    r.done_res   = dn;
    r.failed     = fl;
    r.byte_count = cnt;
    r.last       = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void arm(phase_e nxt);
    seq_phase    = nxt;
    ticks_waited = '0;
  endfunction

  // attempt budget check, then a start or a failed finish
  function automatic void try_start();
    if (attempts >= retry_limit) begin
      emit(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1);
      seq_phase = PH_IDLE;
    end else begin
      attempts++;
      emit(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
      arm(PH_START);
    end
  endfunction

  // no stop while a start is still pending
  function automatic void abort();
    if (seq_phase == PH_START)
      emit(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1);
    else
      emit(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1);
    seq_phase = PH_IDLE;
  endfunction

  function automatic void finish(logic rxv, logic [7:0] rxd);
    emit(ACT_STOP, 8'h00, rxv, rxd, 1'b1, 1'b0, moved, 1'b1);
    seq_phase = PH_IDLE;
  endfunction

  function automatic void xmit(logic [7:0] b, phase_e nxt);
    emit(ACT_SEND, b, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    arm(nxt);
  endfunction

  function automatic void restart_bus();
    emit(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    arm(PH_START);
  endfunction

  function automatic void rx_next(logic rxv, logic [7:0] rxd);
    remaining--;
    emit((remaining != 0) ? ACT_RACK : ACT_RNACK, 8'h00, rxv, rxd, 1'b0, 1'b0, 8'h00, 1'b1);
    arm(PH_RX);
  endfunction

  function automatic void request_byte();
    emit(ACT_REQ, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    seq_phase = PH_TXNEED;
  endfunction

  // reaction to one bus status event
  function automatic void bus_event(logic [7:0] st, logic [7:0] rx);
    case (seq_phase)
      PH_START: begin
        if (st == ST_START || st == ST_RSTART) xmit(dev_q, PH_SLAW);
        else if (st == ST_ARB_LOST) restart_bus();
        else abort();
      end
      PH_SLAW: begin
        if (st == ST_SLAW_ACK) xmit(sub_q, PH_SUB);
        else if (st == ST_SLAW_NACK) begin
          emit(ACT_DIS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
          try_start();
        end else if (st == ST_ARB_LOST) restart_bus();
        else abort();
      end
      PH_SUB: begin
        if (st == ST_DATA_ACK) begin
          if (rd_xfer) begin
            emit(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
            arm(PH_RSTART);
          end else if (remaining == 0) finish(1'b0, 8'h00);
          else request_byte();
        end else if (st == ST_DATA_NACK) finish(1'b0, 8'h00);
        else if (st == ST_ARB_LOST) restart_bus();
        else abort();
      end
      PH_RSTART: begin
        if (st == ST_START || st == ST_RSTART) xmit(dev_q | 8'h01, PH_SLAR);
        else if (st == ST_ARB_LOST) restart_bus();
        else abort();
      end
      PH_SLAR: begin
        if (st == ST_SLAR_ACK) begin
          if (remaining == 0) finish(1'b0, 8'h00);
          else rx_next(1'b0, 8'h00);
        end else if (st == ST_SLAR_NACK) finish(1'b0, 8'h00);
        else if (st == ST_ARB_LOST) restart_bus();
        else abort();
      end
      PH_RX: begin
        if (st == ST_RX_NACK || st == ST_RX_ACK) begin
          moved++;
          if (st == ST_RX_NACK || remaining == 0) finish(1'b1, rx);
          else rx_next(1'b1, rx);
        end else abort();
      end
      PH_TXWAIT: begin
        if (st == ST_DATA_ACK) begin
          moved++;
          if (remaining == 0) finish(1'b0, 8'h00);
          else request_byte();
        end else abort();
      end
      PH_TXNEED: abort();
      default: ;
    endcase
  endfunction

  // one accepted command transfer
  function automatic void sequence_step(logic [2:0] f, logic [7:0] dev, logic [7:0] sub,
                                        logic [7:0] len, logic [7:0] st, logic [7:0] rx,
                                        logic [7:0] tx);
    case (f)
      FUNC_READ, FUNC_WRITE: begin
        if (seq_phase == PH_IDLE) begin
          rd_xfer      = (f == FUNC_READ);
          dev_q        = dev;
          sub_q        = sub;
          remaining    = len;
          moved        = '0;
          attempts     = '0;
          ticks_waited = '0;
          emit(ACT_DIS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
          try_start();
        end
      end
      FUNC_EVENT: begin
        if (seq_phase != PH_IDLE) bus_event(st, rx);
      end
      FUNC_TICK: begin
        if (seq_phase != PH_IDLE && seq_phase != PH_TXNEED) begin
          if (ticks_waited != 16'hFFFF) ticks_waited++;
          if (ticks_waited >= tick_limit) abort();
        end
      end
      FUNC_BYTE: begin
        if (seq_phase == PH_TXNEED) begin
          remaining--;
          xmit(tx, PH_TXWAIT);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("t=%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // follow both channels at each rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      retry_limit  = MAX_RETRIES_RST;
      tick_limit   = TIMEOUT_RST;
      seq_phase    = PH_IDLE;
      rd_xfer      = 1'b0;
      dev_q        = '0;
      sub_q        = '0;
      remaining    = '0;
      moved        = '0;
      attempts     = '0;
      ticks_waited = '0;
      errors       = 0;
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_MAX_RETRIES) retry_limit = cfg_data[7:0];
        else tick_limit = cfg_data[15:0];
      end
      if (in_ch.valid && in_ch.ready)
        sequence_step(in_ch.func, in_ch.dev_addr, in_ch.sub_addr, in_ch.length,
                      in_ch.bus_status, in_ch.rx_byte, in_ch.tx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("t=%0t result with none expected: action %0d out_byte %0h done %0b failed %0b",
                   $time, out_ch.action, out_ch.out_byte, out_ch.done_res, out_ch.failed);
        end else begin
          want = pending_results.pop_front();
          check_field("action", want.action, out_ch.action);
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("rx_valid", want.rx_valid, out_ch.rx_valid);
          check_field("rx_data", want.rx_data, out_ch.rx_data);
          check_field("done_res", want.done_res, out_ch.done_res);
          check_field("failed", want.failed, out_ch.failed);
          check_field("byte_count", want.byte_count, out_ch.byte_count);
          check_field("last", want.last, out_ch.last);
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the register transfer sequencer with a short directed run, then
// with random register transfers under several retry and timeout settings:
// mostly complete bus conversations with random detours (arbitration loss,
// address and data NACKs, timeouts, stray status codes, ignored commands)
// and some random noise. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb;
  import i2crt_pkg::*;

  localparam logic [2:0] FUNC_UNUSED  = 3'd7;
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam int         PHASES       = 6;
  localparam int         ITEM_GOAL    = 1100;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    outstanding;

  // stimulus side knowledge of the settings
  bit                    gaps_on;
  logic [7:0]            retries_now;
  int                    tick_limit_now;
  int                    items_sent;

  i2crt_in_if  in_ch ();
  i2crt_out_if out_ch ();

  i2c_register_transfer_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  i2crt_checker i_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready = gaps_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // one command transfer, with a random idle gap in front
  task automatic drive_item(logic [2:0] f, logic [7:0] dev, logic [7:0] sub, logic [7:0] len,
                            logic [7:0] st, logic [7:0] rx, logic [7:0] tx);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.func       = f;
    in_ch.dev_addr   = dev;
    in_ch.sub_addr   = sub;
    in_ch.length     = len;
    in_ch.bus_status = st;
    in_ch.rx_byte    = rx;
    in_ch.tx_byte    = tx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic bus_ev(logic [7:0] st);
    drive_item(FUNC_EVENT, rnd_byte(), rnd_byte(), rnd_byte(), st, rnd_byte(), rnd_byte());
  endtask

  task automatic tick();
    drive_item(FUNC_TICK, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
               rnd_byte());
  endtask

  task automatic host_byte(logic [7:0] b);
    drive_item(FUNC_BYTE, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), b);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apply_settings(logic [7:0] r, logic [15:0] t);
    write_reg(CFG_MAX_RETRIES, {rnd_byte(), r});
    write_reg(CFG_TIMEOUT, t);
    retries_now    = r;
    tick_limit_now = (t == 0) ? 1 : int'(t);
  endtask

  // one register transfer that mostly follows the bus protocol
  task automatic run_transfer();
    bit         rd;
    int         n;
    int         tries;
    int         roll;
    logic [7:0] dev;
    logic [7:0] stray;
    phase_e     at;
    rd   = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 1) n = 255;
    else if (roll < 4) n = $urandom_range(17, 64);
    else if (roll < 30) n = $urandom_range(5, 16);
    else n = $urandom_range(0, 4);
    dev = ($urandom_range(0, 99) < 85) ? {7'($urandom_range(0, 127)), 1'b0} : rnd_byte();
    drive_item(rd ? FUNC_READ : FUNC_WRITE, dev, rnd_byte(), 8'(n), rnd_byte(), rnd_byte(),
               rnd_byte());
    if (retries_now == 0) return;
    tries = 1;
    at    = PH_START;
    while (at != PH_IDLE) begin
      // ticks while waiting: mostly short of the limit, sometimes all the way
      if (at == PH_TXNEED) begin
        if ($urandom_range(0, 99) < 20) tick();
      end else if (tick_limit_now > 1 && $urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(1, (tick_limit_now > 3) ? 3 : tick_limit_now - 1)) tick();
      end else if (tick_limit_now <= 8 && $urandom_range(0, 99) < 4) begin
        repeat (tick_limit_now) tick();
        at = PH_IDLE;
      end
      if (at == PH_IDLE) break;
      // commands the block ignores while busy
      if ($urandom_range(0, 99) < 3) begin
        if (at != PH_TXNEED && $urandom_range(0, 1))
          host_byte(rnd_byte());
        else
          drive_item($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE, rnd_byte(), rnd_byte(),
                     rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        // status that does not fit the current phase
        stray = $urandom_range(0, 1) ? {5'($urandom_range(0, 31)), 3'($urandom_range(1, 7))}
                                     : ((at == PH_SLAR) ? ST_RX_NACK : ST_SLAR_NACK);
        bus_ev(stray);
        at = PH_IDLE;
        continue;
      end
      case (at)
        PH_START: begin
          if (roll < 8) bus_ev(ST_ARB_LOST);
          else begin
            bus_ev($urandom_range(0, 1) ? ST_START : ST_RSTART);
            at = PH_SLAW;
          end
        end
        PH_SLAW: begin
          if (roll < 12) begin
            bus_ev(ST_SLAW_NACK);
            if (tries >= retries_now) at = PH_IDLE;
            else begin
              tries++;
              at = PH_START;
            end
          end else if (roll < 16) begin
            bus_ev(ST_ARB_LOST);
            at = PH_START;
          end else begin
            bus_ev(ST_SLAW_ACK);
            at = PH_SUB;
          end
        end
        PH_SUB: begin
          if (roll < 6) begin
            bus_ev(ST_ARB_LOST);
            at = PH_START;
          end else if (roll < 10) begin
            bus_ev(ST_DATA_NACK);
            at = PH_IDLE;
          end else begin
            bus_ev(ST_DATA_ACK);
            if (rd) at = PH_RSTART;
            else if (n == 0) at = PH_IDLE;
            else at = PH_TXNEED;
          end
        end
        PH_RSTART: begin
          if (roll < 6) begin
            bus_ev(ST_ARB_LOST);
            at = PH_START;
          end else begin
            bus_ev($urandom_range(0, 1) ? ST_START : ST_RSTART);
            at = PH_SLAR;
          end
        end
        PH_SLAR: begin
          if (roll < 6) begin
            bus_ev(ST_ARB_LOST);
            at = PH_START;
          end else if (roll < 10) begin
            bus_ev(ST_SLAR_NACK);
            at = PH_IDLE;
          end else begin
            bus_ev(ST_SLAR_ACK);
            at = (n == 0) ? PH_IDLE : PH_RX;
          end
        end
        PH_RX: begin
          n--;
          if (n == 0) begin
            bus_ev($urandom_range(0, 1) ? ST_RX_NACK : ST_RX_ACK);
            at = PH_IDLE;
          end else if (roll < 6) begin
            bus_ev(ST_RX_NACK);
            at = PH_IDLE;
          end else bus_ev(ST_RX_ACK);
        end
        PH_TXNEED: begin
          host_byte(rnd_byte());
          n--;
          at = PH_TXWAIT;
        end
        PH_TXWAIT: begin
          if (roll < 6) begin
            bus_ev(ST_DATA_NACK);
            at = PH_IDLE;
          end else begin
            bus_ev(ST_DATA_ACK);
            at = (n == 0) ? PH_IDLE : PH_TXNEED;
          end
        end
        default: at = PH_IDLE;
      endcase
    end
  endtask

  // run limit
  initial begin
    #5000000;
    $display("i2c_register_transfer_master verification failed");
    $finish;
  end

  // stimulus
  initial begin
    logic [7:0]  r_set [PHASES];
    logic [15:0] t_set [PHASES];
    int          goal;
    r_set = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd3};
    t_set = '{16'd65535, 16'd1, 16'd0, 16'd7, 16'd4, 16'd1000};
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = CFG_MAX_RETRIES;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_TICK;
    in_ch.dev_addr   = '0;
    in_ch.sub_addr   = '0;
    in_ch.length     = '0;
    in_ch.bus_status = '0;
    in_ch.rx_byte    = '0;
    in_ch.tx_byte    = '0;
    gaps_on          = 1'b1;
    retries_now      = MAX_RETRIES_RST;
    tick_limit_now   = int'(TIMEOUT_RST);
    items_sent       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // write of one byte, with a tick while the host byte is awaited
    drive_item(FUNC_WRITE, 8'hFE, 8'hFF, 8'd1, 8'h00, 8'h00, 8'h00);
    bus_ev(ST_START);
    bus_ev(ST_SLAW_ACK);
    bus_ev(ST_DATA_ACK);
    tick();
    host_byte(8'hFF);
    bus_ev(ST_DATA_ACK);
    // long read: arbitration loss, address nack, repeated start, early end
    drive_item(FUNC_READ, 8'h00, 8'h00, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    bus_ev(ST_RSTART);
    bus_ev(ST_ARB_LOST);
    bus_ev(ST_START);
    bus_ev(ST_SLAW_NACK);
    bus_ev(ST_START);
    bus_ev(ST_SLAW_ACK);
    bus_ev(ST_DATA_ACK);
    bus_ev(ST_RSTART);
    bus_ev(ST_SLAR_ACK);
    drive_item(FUNC_EVENT, 8'h00, 8'h00, 8'h00, ST_RX_ACK, 8'hFF, 8'h00);
    drive_item(FUNC_EVENT, 8'hFF, 8'hFF, 8'hFF, ST_RX_NACK, 8'h00, 8'hFF);
    // commands that mean nothing while idle
    bus_ev(ST_START);
    tick();
    drive_item(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    host_byte(8'hA5);
    // bus error while the first start is pending
    drive_item(FUNC_WRITE, 8'h80, 8'h01, 8'd0, 8'h00, 8'h00, 8'h00);
    bus_ev(ST_BUS_ERROR);

    // random transfers under several settings, one phase without idling
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 4)
        apply_settings(8'($urandom_range(1, 8)), 16'($urandom_range(2, 8)));
      else
        apply_settings(r_set[p], t_set[p]);
      gaps_on = (p != 2);
      goal    = 25 + (p + 1) * ITEM_GOAL / PHASES;
      while (items_sent < goal) begin
        if ($urandom_range(0, 99) < 82) run_transfer();
        else begin
          repeat ($urandom_range(1, 4))
            drive_item(3'($urandom_range(0, 7)), rnd_byte(), rnd_byte(), rnd_byte(),
                       rnd_byte(), rnd_byte(), rnd_byte());
          // a bus error brings back idle whatever the noise started
          bus_ev(ST_BUS_ERROR);
        end
      end
    end
    gaps_on = 1'b1;

    settle();
    repeat (12) @(negedge clk);
    if (errors == 0 && outstanding == 0)
      $display("i2c_register_transfer_master verification clean");
    else
      $display("i2c_register_transfer_master verification failed");
    $finish;
  end

endmodule
